// ----- rtl/kvk_pkg.sv -----
package kvk_pkg;

  localparam int KEY_W  = 32;
  localparam int DIST_W = 38;
  localparam int VAL_W  = 16;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [0:0] REG_TABLE_READY = 1'd0;

  typedef struct packed {
    logic        op;
    logic [7:0]  slot;
    logic [4:0]  component;
    logic [31:0] entry_key;
    logic signed [15:0] value;
    logic        entry_valid;
    logic [7:0]  max_count;
  } in_item_t;

  typedef struct packed {
    logic [31:0] neighbour_key;
    logic [37:0] distance;
    logic        found;
    logic        last;
  } out_item_t;

endpackage

// ----- rtl/keyed_vector_knn_topk.sv -----
// Keyed k-nearest-neighbor search over a table of Q1.15 vectors. Write items
// load one vector component plus the slot's key and valid mark and are taken
// while the back end stays idle. A query first probes the key table slot by
// slot until it finds the key, then visits every slot: for a candidate it
// makes two vector memory reads per component through one read port, drains
// the square-and-add pipeline and does the sorted top-K insert, then it closes
// the scan. Results then follow at one per cycle while out_ready is high. A
// two-entry queue in front holds items that arrive while a query runs. The
// table_ready register lies at address 0.
module keyed_vector_knn_topk #(
  parameter int ENTRIES = 256,
  parameter int DIMS    = 32,
  parameter int MAX_K   = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  kvk_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output kvk_pkg::out_item_t out_data,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [1:0]         cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready
);

  logic ready_r;
  logic q_valid, q_ready;
  kvk_pkg::in_item_t q_data;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[1:0] == 2'd0) ? {31'd0, ready_r} : 32'd0;

  // hold table_ready register
  always_ff @(posedge clk) begin
    if (!rst_n) ready_r <= 1'b0;
    else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == 2'd0)
      ready_r <= cfg_pwdata[0];
  end

  kvk_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_data,
    .q_valid, .q_ready, .q_data
  );

  kvk_back #(.ENTRIES(ENTRIES), .DIMS(DIMS), .MAX_K(MAX_K)) u_back (
    .clk, .rst_n, .table_ready(ready_r), .q_valid, .q_ready, .q_data,
    .out_valid, .out_ready, .out_data
  );

endmodule

// ----- rtl/kvk_front.sv -----
module kvk_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  kvk_pkg::in_item_t in_data,
  output logic              q_valid,
  input  logic              q_ready,
  output kvk_pkg::in_item_t q_data
);

  // two-entry queue between front and back
  kvk_pkg::in_item_t buf_r [2];
  logic [1:0] cnt_r;
  logic       wp_r, rp_r;

  assign in_ready = (cnt_r != 2'd2);
  assign q_valid  = (cnt_r != 2'd0);
  assign q_data   = buf_r[rp_r];

  // advance pointers on each transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        buf_r[wp_r] <= in_data;
        wp_r        <= ~wp_r;
      end
      if (q_valid && q_ready) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, in_valid && in_ready} - {1'b0, q_valid && q_ready};
    end
  end

endmodule

// ----- rtl/kvk_back.sv -----
module kvk_back #(
  parameter int ENTRIES = 256,
  parameter int DIMS    = 32,
  parameter int MAX_K   = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               table_ready,
  input  logic               q_valid,
  output logic               q_ready,
  input  kvk_pkg::in_item_t  q_data,
  output logic               out_valid,
  input  logic               out_ready,
  output kvk_pkg::out_item_t out_data
);

  localparam int SW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int DW = (DIMS > 1) ? $clog2(DIMS) : 1;
  localparam int KW = $clog2(MAX_K + 1);
  localparam int PW = (MAX_K > 1) ? $clog2(MAX_K) : 1;
  localparam int AW = SW + DW;
  localparam logic [37:0] DMAX = '1;

  localparam logic [2:0] S_IDLE = 3'd0, S_FIND = 3'd1, S_SCAN = 3'd2,
                         S_DIST = 3'd3, S_INS = 3'd4, S_EMIT = 3'd5;

  logic [2:0] st_r;

  // storage
  logic [15:0] vmem [ENTRIES*DIMS];
  logic [31:0] kmem [ENTRIES];
  logic [ENTRIES-1:0] valid_r;
  logic [31:0] bk_r [MAX_K];
  logic [37:0] bd_r [MAX_K];

  logic [31:0] qkey_r;
  logic [KW-1:0] lim_r, fill_r, oidx_r;
  logic [SW-1:0] qs_r, cs_r;
  logic [SW:0]   sc_r;
  logic [DW:0]   dc_r;
  logic [39:0]   acc_r;
  logic [31:0]   ckey_r;
  logic          kv_r, rd_ph_r;
  logic [31:0]   krd_r;
  logic [15:0]   va_r, vb_r;
  logic          pend_r;
  logic [33:0]   sq_r;
  logic          bp_r, dv_r, sqv_r;
  logic          empty_r;

  wire [SW-1:0] sidx = sc_r[SW-1:0];
  wire [DW-1:0] didx = dc_r[DW-1:0];
  wire in_wr = q_data.op == kvk_pkg::OP_WRITE;

  assign q_ready = (st_r == S_IDLE);

  // output item, driven combinationally from the result registers
  assign out_valid = (st_r == S_EMIT);
  always_comb begin
    out_data = '0;
    out_data.last = empty_r || (oidx_r + 1'b1 == fill_r);
    if (!empty_r) begin
      out_data.neighbour_key = bk_r[oidx_r[PW-1:0]];
      out_data.distance      = bd_r[oidx_r[PW-1:0]];
      out_data.found         = 1'b1;
    end
  end

  // vector memory write and two reads from one read port, alternating
  logic [AW-1:0] raddr;
  always_comb raddr = rd_ph_r ? {cs_r, didx} : {qs_r, didx};
  logic [15:0] vrd_r;
  always_ff @(posedge clk) begin
    if (q_valid && q_ready && in_wr && q_data.slot < ENTRIES && q_data.component < DIMS)
      vmem[{q_data.slot[SW-1:0], q_data.component[DW-1:0]}] <= q_data.value;
    vrd_r <= vmem[raddr];
  end
  always_ff @(posedge clk) begin
    if (q_valid && q_ready && in_wr && q_data.slot < ENTRIES && q_data.component < DIMS)
      kmem[q_data.slot[SW-1:0]] <= q_data.entry_key;
    krd_r <= kmem[sidx];
  end

  // insertion position search helpers
  wire [37:0] dsat = (acc_r > {2'b0, DMAX}) ? DMAX : acc_r[37:0];
  logic [KW-1:0] ipos;
  logic          take;
  always_comb begin
    ipos = '0;
    for (int i = 0; i < MAX_K; i++)
      if (i < fill_r && bd_r[i] <= dsat) ipos = KW'(i + 1);
    take = (fill_r < lim_r) || (dsat < bd_r[lim_r[PW-1:0] - 1'b1]);
  end

  // magnitude of the component difference
  logic signed [16:0] diff;
  logic [16:0]        mag;
  always_comb diff = $signed({va_r[15], va_r}) - $signed({vb_r[15], vb_r});
  always_comb mag = diff[16] ? 17'(-diff) : 17'(diff);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= S_IDLE;
      valid_r <= '0;
      lim_r   <= '0;
      fill_r  <= '0;
      oidx_r  <= '0;
      pend_r  <= 1'b0;
      empty_r <= 1'b1;
    end else begin
      case (st_r)
        S_IDLE: if (q_valid) begin
          if (in_wr) begin
            if (q_data.slot < ENTRIES && q_data.component < DIMS)
              valid_r[q_data.slot[SW-1:0]] <= q_data.entry_valid;
          end else begin
            qkey_r  <= q_data.entry_key;
            lim_r   <= (q_data.max_count > MAX_K) ? KW'(MAX_K) : KW'(q_data.max_count);
            fill_r  <= '0;
            oidx_r  <= '0;
            sc_r    <= '0;
            pend_r  <= 1'b0;
            empty_r <= 1'b1;
            st_r    <= (table_ready && q_data.max_count != 0) ? S_FIND : S_EMIT;
          end
        end
        // walk slots for the query key, reading one key per slot
        S_FIND: begin
          if (!pend_r) begin
            pend_r <= 1'b1;
            kv_r   <= valid_r[sidx];
          end else begin
            pend_r <= 1'b0;
            if (kv_r && krd_r == qkey_r) begin
              qs_r    <= sidx;
              empty_r <= 1'b0;
              sc_r    <= '0;
              st_r    <= S_SCAN;
            end else if (sc_r == (SW+1)'(ENTRIES - 1)) begin
              st_r <= S_EMIT;
            end else begin
              sc_r <= sc_r + 1'b1;
            end
          end
        end
        // pick next candidate slot
        S_SCAN: begin
          if (sc_r == (SW+1)'(ENTRIES)) begin
            empty_r <= (fill_r == 0);
            st_r    <= S_EMIT;
          end else if (!pend_r) begin
            pend_r <= 1'b1;
            kv_r   <= valid_r[sidx];
          end else begin
            pend_r <= 1'b0;
            if (kv_r && krd_r != qkey_r) begin
              cs_r    <= sidx;
              ckey_r  <= krd_r;
              dc_r    <= '0;
              acc_r   <= '0;
              rd_ph_r <= 1'b0;
              bp_r    <= 1'b0;
              dv_r    <= 1'b0;
              sqv_r   <= 1'b0;
              st_r    <= S_DIST;
            end else begin
              sc_r <= sc_r + 1'b1;
            end
          end
        end
        // accumulate squared differences: read a, read b, square, add
        S_DIST: begin
          rd_ph_r <= ~rd_ph_r;
          if (rd_ph_r && dc_r != (DW+1)'(DIMS)) begin
            va_r <= vrd_r;
            dc_r <= dc_r + 1'b1;
          end
          bp_r <= rd_ph_r && dc_r != (DW+1)'(DIMS);
          if (bp_r) vb_r <= vrd_r;
          dv_r <= bp_r;
          if (dv_r) sq_r <= {17'd0, mag} * {17'd0, mag};
          sqv_r <= dv_r;
          if (sqv_r) acc_r <= acc_r + {6'b0, sq_r};
          if (dc_r == (DW+1)'(DIMS) && !bp_r && !dv_r && !sqv_r) st_r <= S_INS;
        end
        // sorted insert, shifting larger entries down
        S_INS: begin
          if (take) begin
            for (int i = MAX_K - 1; i > 0; i--)
              if (KW'(i) > ipos && KW'(i) < lim_r) begin
                bd_r[i] <= bd_r[i-1];
                bk_r[i] <= bk_r[i-1];
              end
            bd_r[ipos[PW-1:0]] <= dsat;
            bk_r[ipos[PW-1:0]] <= ckey_r;
            if (fill_r < lim_r) fill_r <= fill_r + 1'b1;
          end
          sc_r <= sc_r + 1'b1;
          st_r <= S_SCAN;
        end
        S_EMIT: if (out_ready) begin
          if (out_data.last) st_r <= S_IDLE;
          else oidx_r <= oidx_r + 1'b1;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_fill: assert property (@(posedge clk) disable iff (!rst_n) fill_r <= lim_r)
    else $error("fill count above limit");
  a_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !empty_r |-> fill_r != 0) else $error("emit without neighbours");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !q_ready) else $error("accept while emitting");
`endif

endmodule
